[hdl/ubos_pkg.sv]
`default_nettype none

package ubos_pkg;

  localparam int UTIL_W      = 24;
  localparam int FRAC_BITS   = 8;
  localparam int RAND_W      = 16;
  localparam int OP_W        = 2;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CHOSEN_W    = 3;
  localparam int TIE_W       = 4;
  localparam int NUM_OPS_DEF = 8;

  // Square root works on the utility shifted left by the fraction width.
  localparam int SQ_IN_W = UTIL_W + FRAC_BITS;
  localparam int ROOT_W  = (SQ_IN_W + 1) / 2;
  localparam int X_W     = 2 * ROOT_W;

  localparam logic [UTIL_W-1:0] UTIL_ONE  = UTIL_W'(1) << FRAC_BITS;
  localparam logic [UTIL_W-1:0] UTIL_MAX  = '1;
  localparam logic [UTIL_W-1:0] UPPER_RST = UTIL_W'(10240);
  localparam logic [UTIL_W-1:0] LOWER_RST = '0;
  localparam logic [UTIL_W-1:0] INIT_RST  = UTIL_W'(5120);

  localparam logic [OP_W-1:0] OP_SELECT   = OP_W'(0);
  localparam logic [OP_W-1:0] OP_FEEDBACK = OP_W'(1);
  localparam logic [OP_W-1:0] OP_RESTART  = OP_W'(2);

  localparam logic [MODE_W-1:0] REW_ADD    = MODE_W'(0);
  localparam logic [MODE_W-1:0] REW_DOUBLE = MODE_W'(1);
  localparam logic [MODE_W-1:0] REW_SQUARE = MODE_W'(2);

  localparam logic [MODE_W-1:0] PEN_SUB   = MODE_W'(0);
  localparam logic [MODE_W-1:0] PEN_HALVE = MODE_W'(1);
  localparam logic [MODE_W-1:0] PEN_SQRT  = MODE_W'(2);

  localparam logic [CFG_IDX_W-1:0] REG_UPPER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LOWER = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_INIT  = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_PMODE = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_RMODE = CFG_IDX_W'(4);

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } itu_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } itu_stat_t;

endpackage

`default_nettype wire

[hdl/ubos_channels.sv]
`default_nettype none

interface ubos_in_if;
  logic                         valid;
  logic                         ready;
  logic [ubos_pkg::OP_W-1:0]    op;
  logic                         improved;
  logic [ubos_pkg::RAND_W-1:0]  random_word;

  modport source (output valid, output op, output improved, output random_word, input ready);
  modport sink   (input valid, input op, input improved, input random_word, output ready);
endinterface

interface ubos_out_if;
  logic                           valid;
  logic                           ready;
  logic [ubos_pkg::CHOSEN_W-1:0]  chosen_operator;
  logic [ubos_pkg::UTIL_W-1:0]    touched_utility;
  logic [ubos_pkg::TIE_W-1:0]     tie_count;

  modport source (output valid, output chosen_operator, output touched_utility,
                  output tie_count, input ready);
  modport sink   (input valid, input chosen_operator, input touched_utility,
                  input tie_count, output ready);
endinterface

`default_nettype wire

[hdl/utility_based_operator_selector_core.sv]
`default_nettype none

// Utility-based operator selector. A utility table with one Q16.8 entry per
// operator sits in a single-port memory that is read one entry per cycle, and
// one restoring step unit does both the tie-break remainder and the square
// root, one step per cycle. Only one transaction is in work at a time; the
// next is taken once the result is in the output register. A select makes
// one scan of the table, sixteen remainder steps and a second scan that
// stops at the chosen entry. A feedback reads the entry, computes the new
// utility (through a squaring step or the square root where the mode asks
// for one), clamps it and writes it back; an unused op code only reads the
// entry, and a restart goes straight to the result. While a result waits
// to be taken, the next transaction is still accepted and worked on, and
// it waits at its end until the output register is free.
// A restart marks every entry as holding the initial utility by clearing the valid bits and setting the fill value.
module utility_based_operator_selector_core #(
  parameter int NUM_OPS = ubos_pkg::NUM_OPS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [ubos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [ubos_pkg::UTIL_W-1:0]     cfg_data,
  ubos_in_if.sink                              request,
  ubos_out_if.source                           result
);

  localparam int UTIL_W    = ubos_pkg::UTIL_W;
  localparam int FRAC_BITS = ubos_pkg::FRAC_BITS;
  localparam int MODE_W    = ubos_pkg::MODE_W;
  localparam int OP_W      = ubos_pkg::OP_W;
  localparam int RAND_W    = ubos_pkg::RAND_W;
  localparam int ROOT_W    = ubos_pkg::ROOT_W;
  localparam int X_W       = ubos_pkg::X_W;
  localparam int CHOSEN_W  = ubos_pkg::CHOSEN_W;
  localparam int TIE_W     = ubos_pkg::TIE_W;
  localparam int IDX_W     = $clog2(NUM_OPS);
  localparam int CNT_W     = $clog2(NUM_OPS + 1);
  localparam int PROD_W    = 2 * UTIL_W;

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SCAN      = 4'd1;
  localparam logic [3:0] S_MOD_GO    = 4'd2;
  localparam logic [3:0] S_MOD_WAIT  = 4'd3;
  localparam logic [3:0] S_PICK      = 4'd4;
  localparam logic [3:0] S_FB_READ   = 4'd5;
  localparam logic [3:0] S_FB_CALC   = 4'd6;
  localparam logic [3:0] S_SQUARE    = 4'd7;
  localparam logic [3:0] S_SQRT_GO   = 4'd8;
  localparam logic [3:0] S_SQRT_WAIT = 4'd9;
  localparam logic [3:0] S_CLAMP     = 4'd10;
  localparam logic [3:0] S_FIN       = 4'd11;

  logic [3:0]          state;

  logic [UTIL_W-1:0]   upper_bound;
  logic [UTIL_W-1:0]   lower_bound;
  logic [UTIL_W-1:0]   initial_utility;
  logic [MODE_W-1:0]   penalty_mode;
  logic [MODE_W-1:0]   reward_mode;

  logic [UTIL_W-1:0]   util_mem [NUM_OPS];
  logic [NUM_OPS-1:0]  ent_valid;
  logic [UTIL_W-1:0]   fill_value;
  logic [IDX_W-1:0]    rd_addr;
  logic [UTIL_W-1:0]   rd_data;
  logic                rd_vbit;
  logic                rd_vld;
  logic [IDX_W-1:0]    rd_idx;
  logic [UTIL_W-1:0]   entry_val;
  logic                mem_we;
  logic [UTIL_W-1:0]   clamp_val;

  logic [IDX_W-1:0]    last_chosen;
  logic [CNT_W-1:0]    scan_cnt;
  logic                issuing;
  logic [UTIL_W-1:0]   best;
  logic [CNT_W-1:0]    ties;
  logic [CNT_W-1:0]    seen;
  logic [OP_W-1:0]     op_q;
  logic                improved_q;
  logic [RAND_W-1:0]   rnd_q;
  logic [UTIL_W-1:0]   work;
  logic [PROD_W-1:0]   prod;
  logic [UTIL_W-1:0]   raw;
  logic [UTIL_W:0]     sum_one;

  logic [IDX_W-1:0]    res_idx;
  logic [UTIL_W-1:0]   res_util;
  logic [CNT_W-1:0]    res_ties;
  logic [IDX_W+CHOSEN_W-1:0] idx_ext;
  logic [CNT_W+TIE_W-1:0]    ties_ext;

  logic                out_valid;
  logic [CHOSEN_W-1:0] out_chosen;
  logic [UTIL_W-1:0]   out_util;
  logic [TIE_W-1:0]    out_ties;
  logic                fin_load;
  logic                in_take;

  ubos_pkg::itu_req_t  itu_req;
  ubos_pkg::itu_stat_t itu_stat;
  logic [X_W-1:0]      itu_x;
  logic [ROOT_W-1:0]   itu_root;
  logic [CNT_W-1:0]    itu_rem;

  assign in_take  = request.valid && request.ready;
  assign fin_load = (state == S_FIN) && (!out_valid || result.ready);
  assign issuing  = ((state == S_SCAN) || (state == S_PICK)) && (scan_cnt != CNT_W'(NUM_OPS));
  assign rd_addr  = ((state == S_SCAN) || (state == S_PICK)) ? scan_cnt[IDX_W-1:0] : last_chosen;
  assign entry_val = rd_vbit ? rd_data : fill_value;
  assign sum_one  = {1'b0, entry_val} + (UTIL_W+1)'(ubos_pkg::UTIL_ONE);
  assign mem_we   = (state == S_CLAMP);

  always_comb begin
    if (improved_q) begin
      clamp_val = (raw < upper_bound) ? raw : upper_bound;
    end else begin
      clamp_val = (raw > lower_bound) ? raw : lower_bound;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      util_mem[last_chosen] <= clamp_val;
    end
    rd_data <= util_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_bound     <= ubos_pkg::UPPER_RST;
      lower_bound     <= ubos_pkg::LOWER_RST;
      initial_utility <= ubos_pkg::INIT_RST;
      penalty_mode    <= ubos_pkg::PEN_HALVE;
      reward_mode     <= ubos_pkg::REW_DOUBLE;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ubos_pkg::REG_UPPER: upper_bound     <= cfg_data;
        ubos_pkg::REG_LOWER: lower_bound     <= cfg_data;
        ubos_pkg::REG_INIT:  initial_utility <= cfg_data;
        ubos_pkg::REG_PMODE: penalty_mode    <= cfg_data[MODE_W-1:0];
        ubos_pkg::REG_RMODE: reward_mode     <= cfg_data[MODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ent_valid   <= '0;
      fill_value  <= ubos_pkg::INIT_RST;
      last_chosen <= '0;
      scan_cnt    <= '0;
      rd_vld      <= 1'b0;
    end else begin
      rd_vld  <= issuing;
      rd_idx  <= rd_addr;
      rd_vbit <= ent_valid[rd_addr];
      if (issuing) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end
      if (mem_we) begin
        ent_valid[last_chosen] <= 1'b1;
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            op_q       <= request.op;
            improved_q <= request.improved;
            rnd_q      <= request.random_word;
            unique case (request.op)
              ubos_pkg::OP_SELECT: begin
                scan_cnt <= '0;
                best     <= '0;
                ties     <= '0;
                state    <= S_SCAN;
              end
              ubos_pkg::OP_RESTART: begin
                ent_valid  <= '0;
                fill_value <= initial_utility;
                res_idx    <= last_chosen;
                res_util   <= initial_utility;
                res_ties   <= '0;
                state      <= S_FIN;
              end
              default: begin
                state <= S_FB_READ;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (rd_vld) begin
            if (entry_val > best) begin
              best <= entry_val;
              ties <= CNT_W'(1);
            end else if (entry_val == best) begin
              ties <= ties + CNT_W'(1);
            end
            if (rd_idx == IDX_W'(NUM_OPS - 1)) begin
              state <= S_MOD_GO;
            end
          end
        end
        S_MOD_GO: begin
          state <= S_MOD_WAIT;
        end
        S_MOD_WAIT: begin
          if (itu_stat.done) begin
            scan_cnt <= '0;
            seen     <= '0;
            state    <= S_PICK;
          end
        end
        S_PICK: begin
          if (rd_vld && (entry_val == best)) begin
            seen <= seen + CNT_W'(1);
            if (seen == itu_rem) begin
              last_chosen <= rd_idx;
              res_idx     <= rd_idx;
              res_util    <= best;
              res_ties    <= ties;
              state       <= S_FIN;
            end
          end
        end
        S_FB_READ: begin
          state <= S_FB_CALC;
        end
        S_FB_CALC: begin
          if (op_q != ubos_pkg::OP_FEEDBACK) begin
            res_idx  <= last_chosen;
            res_util <= entry_val;
            res_ties <= '0;
            state    <= S_FIN;
          end else if (improved_q) begin
            unique case (reward_mode)
              ubos_pkg::REW_ADD: begin
                raw   <= sum_one[UTIL_W] ? ubos_pkg::UTIL_MAX : sum_one[UTIL_W-1:0];
                state <= S_CLAMP;
              end
              ubos_pkg::REW_SQUARE: begin
                prod  <= PROD_W'(entry_val) * PROD_W'(entry_val);
                state <= S_SQUARE;
              end
              default: begin
                raw   <= entry_val[UTIL_W-1] ? ubos_pkg::UTIL_MAX
                                             : {entry_val[UTIL_W-2:0], 1'b0};
                state <= S_CLAMP;
              end
            endcase
          end else begin
            unique case (penalty_mode)
              ubos_pkg::PEN_SUB: begin
                raw   <= (entry_val > ubos_pkg::UTIL_ONE) ? entry_val - ubos_pkg::UTIL_ONE
                                                          : '0;
                state <= S_CLAMP;
              end
              ubos_pkg::PEN_SQRT: begin
                work  <= entry_val;
                state <= S_SQRT_GO;
              end
              default: begin
                raw   <= entry_val >> 1;
                state <= S_CLAMP;
              end
            endcase
          end
        end
        S_SQUARE: begin
          raw   <= (prod[PROD_W-1:UTIL_W+FRAC_BITS] != '0) ? ubos_pkg::UTIL_MAX
                                                           : prod[UTIL_W+FRAC_BITS-1:FRAC_BITS];
          state <= S_CLAMP;
        end
        S_SQRT_GO: begin
          state <= S_SQRT_WAIT;
        end
        S_SQRT_WAIT: begin
          if (itu_stat.done) begin
            raw   <= UTIL_W'(itu_root);
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          res_idx  <= last_chosen;
          res_util <= clamp_val;
          res_ties <= '0;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (fin_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign itu_req.start     = (state == S_MOD_GO) || (state == S_SQRT_GO);
  assign itu_req.sqrt_mode = (state == S_SQRT_GO);
  assign itu_x = itu_req.sqrt_mode ? (X_W'(work) << FRAC_BITS)
                                   : (X_W'(rnd_q) << (X_W - RAND_W));

  ubos_itu #(
    .DIV_W (CNT_W)
  ) u_itu (
    .clk       (clk),
    .rst       (rst),
    .req       (itu_req),
    .x_in      (itu_x),
    .divisor   (ties),
    .stat      (itu_stat),
    .root      (itu_root),
    .remainder (itu_rem)
  );

  assign idx_ext  = {{CHOSEN_W{1'b0}}, res_idx};
  assign ties_ext = {{TIE_W{1'b0}}, res_ties};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid  <= 1'b1;
      out_chosen <= idx_ext[CHOSEN_W-1:0];
      out_util   <= res_util;
      out_ties   <= ties_ext[TIE_W-1:0];
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign request.ready          = (state == S_IDLE);
  assign result.valid           = out_valid;
  assign result.chosen_operator = out_chosen;
  assign result.touched_utility = out_util;
  assign result.tie_count       = out_ties;

  assert property (@(posedge clk) disable iff (rst)
    itu_stat.done |-> $past(itu_stat.busy))
    else $error("Step unit signaled completion without having been busy.");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK) |-> (ties != '0))
    else $error("Tie-break pass entered with no maximal entry counted.");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_PICK) |-> (itu_rem < ties))
    else $error("Tie-break remainder is not below the tie count.");

  assert property (@(posedge clk) disable iff (rst)
    (in_take && (request.op == ubos_pkg::OP_RESTART)) |=> (ent_valid == '0))
    else $error("Restart did not invalidate every table entry.");

endmodule

`default_nettype wire

[hdl/ubos_itu.sv]
`default_nettype none

module ubos_itu #(
  parameter int DIV_W = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire ubos_pkg::itu_req_t              req,
  input  wire logic [ubos_pkg::X_W-1:0]        x_in,
  input  wire logic [DIV_W-1:0]                divisor,
  output ubos_pkg::itu_stat_t                  stat,
  output logic [ubos_pkg::ROOT_W-1:0]          root,
  output logic [DIV_W-1:0]                     remainder
);

  localparam int ROOT_W    = ubos_pkg::ROOT_W;
  localparam int X_W       = ubos_pkg::X_W;
  localparam int RAND_W    = ubos_pkg::RAND_W;
  localparam int REM_W     = (DIV_W + 1 > ROOT_W + 2) ? DIV_W + 1 : ROOT_W + 2;
  localparam int SH_W      = REM_W + 2;
  localparam int MAX_STEPS = (ROOT_W > RAND_W) ? ROOT_W : RAND_W;
  localparam int STEP_W    = $clog2(MAX_STEPS);

  logic [X_W-1:0]    x_sh;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] q;
  logic [STEP_W-1:0] step_cnt;
  logic              busy;
  logic              done;
  logic              sqrt_q;
  logic [DIV_W-1:0]  div_q;

  logic [SH_W-1:0]   rem_sh;
  logic [SH_W-1:0]   trial;
  logic [SH_W-1:0]   diff;
  logic              ge;

  // One restoring step per cycle: two bits of the radicand for a square root,
  // one bit of the dividend for a remainder.
  always_comb begin
    if (sqrt_q) begin
      rem_sh = {rem, x_sh[X_W-1 -: 2]};
      trial  = SH_W'({q, 2'b01});
    end else begin
      rem_sh = {1'b0, rem, x_sh[X_W-1]};
      trial  = SH_W'(div_q);
    end
    ge   = (rem_sh >= trial);
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        x_sh     <= x_in;
        rem      <= '0;
        q        <= '0;
        sqrt_q   <= req.sqrt_mode;
        div_q    <= divisor;
        step_cnt <= req.sqrt_mode ? STEP_W'(ROOT_W - 1) : STEP_W'(RAND_W - 1);
      end else if (busy) begin
        rem      <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        q        <= {q[ROOT_W-2:0], ge};
        x_sh     <= sqrt_q ? (x_sh << 2) : (x_sh << 1);
        step_cnt <= step_cnt - STEP_W'(1);
        if (step_cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign root      = q;
  assign remainder = rem[DIV_W-1:0];

endmodule

`default_nettype wire
